// ----- hdl/frame_interval_meter_assert.svh -----
// ----------------------------------------------------------------------------
// Frame interval meter assertion macros
// Clocked property checks on aclk, disabled or not disabled by aresetn.
// ----------------------------------------------------------------------------
`ifndef FRAME_INTERVAL_METER_ASSERT_SVH
`define FRAME_INTERVAL_METER_ASSERT_SVH

`ifndef SYNTHESIS
// check outside reset
`define FIM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// check that also holds while reset is applied
`define FIM_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define FIM_ASSERT(lbl, prop, msg)
`define FIM_ASSERT_RST(lbl, prop, msg)
`endif

`endif

// ----- hdl/fim_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fim_pkg
// Shared field widths, constants and register indexes of the interval meter.
// ----------------------------------------------------------------------------
package fim_pkg;

    localparam int STAMP_W = 48;
    localparam int DELTA_W = 20;
    localparam int WEIGHT_W = 9;
    localparam int Q8_W = 28;
    localparam int RATE_W = 24;
    localparam int TALLY_W = 40;

    localparam int IN_DATA_W = 56;
    localparam int OUT_DATA_W = 160;
    localparam int CFG_DATA_W = 20;

    localparam logic [DELTA_W-1:0] RING_FILL = 20'd16667;
    localparam logic [DELTA_W-1:0] MAX_DELTA_RST = 20'd100000;
    localparam logic [WEIGHT_W-1:0] WEIGHT_RST = 9'd51;
    localparam logic [WEIGHT_W-1:0] WEIGHT_FULL = 9'd256;
    localparam logic [RATE_W-1:0] RATE_MAX = 24'hFFFFFF;

    typedef enum logic [0:0] {
        CFG_MAX_DELTA = 1'b0,
        CFG_SMOOTH_WEIGHT = 1'b1
    } cfg_index_t;

    typedef enum logic [0:0] {
        ACT_START = 1'b0,
        ACT_FRAME = 1'b1
    } action_t;

endpackage

// ----- hdl/fim_ring.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fim_ring
// Interval ring memory with write pointer and running window sum.
// ----------------------------------------------------------------------------
module fim_ring #(
    parameter int WINDOW = 64
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       restart,
    input  logic                       wr_en,
    input  logic [fim_pkg::DELTA_W-1:0] wr_data,
    output logic [$clog2(WINDOW*64'd1048575+1)-1:0] total
);

    localparam int TOT_W = $clog2(WINDOW * 64'd1048575 + 1);
    localparam int PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam longint TOT_FILL = longint'(WINDOW) * 64'd16667;

    logic [fim_pkg::DELTA_W-1:0] mem [WINDOW];
    logic [fim_pkg::DELTA_W-1:0] rdata_reg;
    logic [PTR_W-1:0]            ptr_reg;
    logic                        full_reg;
    logic [TOT_W-1:0]            total_reg;
    logic [fim_pkg::DELTA_W-1:0] old_val;

    // slot at the pointer holds the fill value until the ring has wrapped once
    assign old_val = full_reg ? rdata_reg : fim_pkg::RING_FILL;

    always_ff @(posedge aclk) begin
        rdata_reg <= mem[ptr_reg];
        if (wr_en) begin
            mem[ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || restart) begin
            ptr_reg <= '0;
            full_reg <= 1'b0;
            total_reg <= TOT_W'(TOT_FILL);
        end else if (wr_en) begin
            total_reg <= total_reg - TOT_W'(old_val) + TOT_W'(wr_data);
            if (ptr_reg == PTR_W'(WINDOW - 1)) begin
                ptr_reg <= '0;
                full_reg <= 1'b1;
            end else begin
                ptr_reg <= ptr_reg + 1'b1;
            end
        end
    end

    assign total = total_reg;

endmodule

// ----- hdl/fim_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fim_div
// Bit-serial restoring divider: WINDOW*256e6 over the window sum, saturated.
// ----------------------------------------------------------------------------
module fim_div #(
    parameter int WINDOW = 64
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [$clog2(WINDOW*64'd1048575+1)-1:0] divisor,
    output logic                       done,
    output logic [fim_pkg::RATE_W-1:0] rate
);

    localparam int TOT_W = $clog2(WINDOW * 64'd1048575 + 1);
    localparam longint NUM_VAL = longint'(WINDOW) * 64'd256000000;
    localparam int NUM_W = $clog2(NUM_VAL + 1);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [TOT_W-1:0] rem_reg;
    logic [NUM_W-1:0] quot_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [TOT_W:0]   shifted;
    logic [TOT_W:0]   diff;
    logic             ge;

    assign shifted = {rem_reg, quot_reg[NUM_W-1]};
    assign diff = shifted - {1'b0, divisor};
    assign ge = shifted >= {1'b0, divisor};

    // a zero divisor gives an all-ones quotient, which saturates below
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quot_reg <= NUM_W'(NUM_VAL);
        end else if (busy_reg) begin
            rem_reg <= ge ? diff[TOT_W-1:0] : shifted[TOT_W-1:0];
            quot_reg <= {quot_reg[NUM_W-2:0], ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                cnt_reg <= CNT_W'(NUM_W);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign rate = (|quot_reg[NUM_W-1:fim_pkg::RATE_W]) ? fim_pkg::RATE_MAX
                                                      : quot_reg[fim_pkg::RATE_W-1:0];

endmodule

// ----- hdl/frame_interval_meter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_interval_meter
// Frame timing meter: clamped interval, smoothed interval and windowed rate.
// ----------------------------------------------------------------------------
// channel   | dir | handshake            | payload
// s_ (item) | in  | s_tvalid / s_tready  | s_tuser action, s_tdata stamp + pause
// m_ (item) | out | m_tvalid / m_tready  | m_tdata delta..paused_now
// cfg       | in  | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// Frame mark: S_CALC, S_MUL, S_UPD, S_RATE, S_DIV, S_OUT; start item: S_RATE,
// S_DIV, S_OUT; paused mark: S_OUT only. NUM_W is the width of WINDOW*256e6
// (34 at WINDOW = 64), one quotient bit per cycle in the serial divider. One
// item at a time; the next item is taken while the result still waits in the
// output register. No ring clearing pass: a wrap flag marks unwritten slots as 16667.
// Reset is synchronous, active low; cfg_ready is always high.
// ----------------------------------------------------------------------------
`include "frame_interval_meter_assert.svh"

module frame_interval_meter #(
    parameter int WINDOW = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [0:0]                      s_tuser,  // [0] action
    input  logic [fim_pkg::IN_DATA_W-1:0]   s_tdata,  // [47:0] timestamp_us, [48] pause
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [19:0] delta_us, [39:20] smooth_us, [63:40] rate_q8, [103:64] frames,
    // [151:104] elapsed_us, [152] paused_now
    output logic [fim_pkg::OUT_DATA_W-1:0]  m_tdata,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [0:0]                      cfg_index,
    input  logic [fim_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int TOT_W = $clog2(WINDOW * 64'd1048575 + 1);
    localparam longint TOT_MAX = longint'(WINDOW) * 64'd1048575;
    localparam int PROD_W = fim_pkg::Q8_W + fim_pkg::WEIGHT_W;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_CALC = 7'b0000010,
        S_MUL  = 7'b0000100,
        S_UPD  = 7'b0001000,
        S_RATE = 7'b0010000,
        S_DIV  = 7'b0100000,
        S_OUT  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [fim_pkg::DELTA_W-1:0]  max_delta_reg;
    logic [fim_pkg::WEIGHT_W-1:0] weight_reg;

    logic [fim_pkg::STAMP_W-1:0] start_stamp_reg;
    logic [fim_pkg::STAMP_W-1:0] cur_stamp_reg;
    logic [fim_pkg::STAMP_W-1:0] in_stamp_reg;
    logic                        pause_reg;
    logic [fim_pkg::DELTA_W-1:0] last_delta_reg;
    logic [fim_pkg::Q8_W-1:0]    smooth_q8_reg;
    logic [fim_pkg::TALLY_W-1:0] tally_reg;
    logic [fim_pkg::RATE_W-1:0]  rate_reg;
    logic [PROD_W-1:0]           prod_a_reg;
    logic [PROD_W-1:0]           prod_b_reg;

    logic                           m_tvalid_reg;
    logic [fim_pkg::OUT_DATA_W-1:0] m_tdata_reg;

    logic                        accept;
    logic                        in_pause;
    logic [fim_pkg::STAMP_W-1:0] in_stamp;
    logic [fim_pkg::STAMP_W-1:0] diff;
    logic [fim_pkg::DELTA_W-1:0] delta_clamped;
    logic [fim_pkg::WEIGHT_W-1:0] w_eff;
    logic [fim_pkg::WEIGHT_W-1:0] inv_w;
    logic [PROD_W:0]             smooth_sum;
    logic                        out_load;
    logic                        ring_restart;
    logic                        ring_wr;
    logic [TOT_W-1:0]            ring_total;
    logic                        div_done;
    logic [fim_pkg::RATE_W-1:0]  div_rate;
    logic [fim_pkg::STAMP_W-1:0] elapsed;
    logic [fim_pkg::OUT_DATA_W-1:0] out_word;

    assign s_tready = (state_reg == S_IDLE);
    assign accept = s_tvalid && s_tready;
    assign in_stamp = s_tdata[fim_pkg::STAMP_W-1:0];
    assign in_pause = s_tdata[fim_pkg::STAMP_W];
    assign cfg_ready = 1'b1;

    assign ring_restart = accept && (s_tuser == fim_pkg::ACT_START);
    assign ring_wr = (state_reg == S_UPD);
    assign out_load = (state_reg == S_OUT) && (!m_tvalid_reg || m_tready);

    // wrapping interval, then clamp
    assign diff = in_stamp_reg - cur_stamp_reg;
    assign delta_clamped = (diff > fim_pkg::STAMP_W'(max_delta_reg)) ? max_delta_reg
                                                                    : diff[fim_pkg::DELTA_W-1:0];

    assign w_eff = weight_reg[fim_pkg::WEIGHT_W-1] ? fim_pkg::WEIGHT_FULL : weight_reg;
    assign inv_w = fim_pkg::WEIGHT_FULL - w_eff;
    assign smooth_sum = (PROD_W+1)'(prod_a_reg) + (PROD_W+1)'(prod_b_reg)
                      + (PROD_W+1)'(128);
    assign elapsed = cur_stamp_reg - start_stamp_reg;

    fim_ring #(
        .WINDOW (WINDOW)
    ) u_ring (
        .aclk    (aclk),
        .aresetn (aresetn),
        .restart (ring_restart),
        .wr_en   (ring_wr),
        .wr_data (last_delta_reg),
        .total   (ring_total)
    );

    fim_div #(
        .WINDOW (WINDOW)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (state_reg == S_RATE),
        .divisor (ring_total),
        .done    (div_done),
        .rate    (div_rate)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (s_tuser == fim_pkg::ACT_START) begin
                        state_next = in_pause ? S_OUT : S_RATE;
                    end else begin
                        state_next = in_pause ? S_OUT : S_CALC;
                    end
                end
            end
            S_CALC: state_next = S_MUL;
            S_MUL:  state_next = S_UPD;
            S_UPD:  state_next = S_RATE;
            S_RATE: state_next = S_DIV;
            S_DIV: begin
                if (div_done) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            max_delta_reg <= fim_pkg::MAX_DELTA_RST;
            weight_reg <= fim_pkg::WEIGHT_RST;
            start_stamp_reg <= '0;
            cur_stamp_reg <= '0;
            last_delta_reg <= '0;
            smooth_q8_reg <= '0;
            tally_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    fim_pkg::CFG_MAX_DELTA:     max_delta_reg <= cfg_data;
                    fim_pkg::CFG_SMOOTH_WEIGHT: weight_reg <= cfg_data[fim_pkg::WEIGHT_W-1:0];
                    default: ;
                endcase
            end
            if (accept) begin
                if (s_tuser == fim_pkg::ACT_START) begin
                    start_stamp_reg <= in_stamp;
                    cur_stamp_reg <= in_stamp;
                end else if (in_pause) begin
                    last_delta_reg <= '0;
                end
            end
            if (state_reg == S_CALC) begin
                cur_stamp_reg <= in_stamp_reg;
                last_delta_reg <= delta_clamped;
            end
            if (state_reg == S_UPD) begin
                smooth_q8_reg <= smooth_sum[fim_pkg::Q8_W+7:8];
                tally_reg <= tally_reg + 1'b1;
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // result word; interval fields read zero while paused
    always_comb begin
        out_word = '0;
        if (!pause_reg) begin
            out_word[19:0] = last_delta_reg;
            out_word[39:20] = smooth_q8_reg[fim_pkg::Q8_W-1:8];
            out_word[63:40] = rate_reg;
        end
        out_word[103:64] = tally_reg;
        out_word[151:104] = elapsed;
        out_word[152] = pause_reg;
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            in_stamp_reg <= in_stamp;
            pause_reg <= in_pause;
        end
        if (state_reg == S_MUL) begin
            prod_a_reg <= smooth_q8_reg * inv_w;
            prod_b_reg <= {last_delta_reg, 8'd0} * w_eff;
        end
        if (div_done) begin
            rate_reg <= div_rate;
        end
        if (out_load) begin
            m_tdata_reg <= out_word;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata = m_tdata_reg;

    `FIM_ASSERT(a_one_item_at_a_time, s_tvalid && s_tready |=> !s_tready, "item taken while busy")
    `FIM_ASSERT(a_div_done_in_div, div_done |-> state_reg == S_DIV, "divider done out of sequence")
    `FIM_ASSERT(a_total_bound, ring_total <= TOT_W'(TOT_MAX), "window sum beyond ring capacity")
    `FIM_ASSERT(a_paused_zero, m_tvalid && m_tdata[152] |-> m_tdata[63:0] == 64'd0, "paused result not zeroed")
    `FIM_ASSERT_RST(a_reset_idle, !aresetn |=> !m_tvalid && s_tready, "reset left work pending")

endmodule
